// ===== rtl/core/tmcw_pkg.sv =====
// Shared constants, codes and memory port types of the text-mode console writer.
// Depends on nothing; every other file of the block imports it.
package tmcw_pkg;

	localparam int COLUMNS = 80;
	localparam int ROWS    = 25;
	localparam int CELLS   = COLUMNS * ROWS;

	localparam int COL_W  = 7;
	localparam int ROW_W  = 5;
	localparam int ADDR_W = 11;
	localparam int CELL_W = 16;

	localparam logic [2:0] FN_PUT_CUR = 3'd0;
	localparam logic [2:0] FN_PUT_POS = 3'd1;
	localparam logic [2:0] FN_SET_CUR = 3'd2;
	localparam logic [2:0] FN_CLEAR   = 3'd3;
	localparam logic [2:0] FN_READ    = 3'd4;

	localparam logic [7:0] BS_CODE = 8'd8;
	localparam logic [7:0] NL_CODE = 8'd10;

	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
		logic [CELL_W-1:0] data;
	} fb_wr_t;

	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
	} fb_rd_t;

endpackage

// ===== rtl/core/tmcw_fbuf.sv =====
// Frame buffer memory: one write port and one read port with registered read data.
// Depends on tmcw_pkg for the cell count and the port request types.
module tmcw_fbuf
	import tmcw_pkg::*;
(
	input  logic              clk,
	input  fb_wr_t            wr,
	input  fb_rd_t            rd,
	output logic [CELL_W-1:0] rdata
);

	logic [CELL_W-1:0] mem [CELLS];

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
	end

	// Read data is registered; it holds until the next read.
	always_ff @(posedge clk) begin
		if (rd.en) begin
			rdata <= mem[rd.addr];
		end
	end

endmodule

// ===== rtl/core/text_mode_console_writer.sv =====
// Top level of the text-mode console writer: cursor control, sweep sequencer and
// result registers around the frame buffer memory. Depends on tmcw_pkg and tmcw_fbuf.
//
// The block keeps an 80 x 25 buffer of 16-bit cells (attribute high byte, character
// low byte) and a cursor. A command beat is taken at a clock edge where start is high
// and busy is low, and every command produces exactly one result beat in the next cycle:
// done is high for that single cycle and the cursor and cell ports are valid only then.
// The receiver cannot stall, so results must be sampled on the done cycle. Ordinary
// commands (put, set cursor, read cell) leave busy low, and a new command may be issued
// every cycle while busy is low. A scroll (newline on the last row, or a character put
// in the last column of the last row) and a clear both walk the whole memory one cell
// per cycle through its single write port, and busy stays high until the sweep and its
// last write are done. After reset the same clearing pass runs before the first command
// is taken. The fill attribute register may be written at any time; a scroll uses the
// value held when it starts.
module text_mode_console_writer
	import tmcw_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic [2:0]        func,
	input  logic [6:0]        pos_x,
	input  logic [4:0]        pos_y,
	input  logic [7:0]        char_code,
	input  logic [7:0]        attribute,
	output logic              done,
	output logic [6:0]        cursor_col,
	output logic [4:0]        cursor_row,
	output logic [10:0]       cursor_offset,
	output logic [15:0]       cell_value,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [7:0]        cfg_data
);

	// Sequencer states: normal command processing, clearing sweep, scroll sweep.
	localparam logic [1:0] ST_RUN    = 2'd0;
	localparam logic [1:0] ST_CLEAR  = 2'd1;
	localparam logic [1:0] ST_SCROLL = 2'd2;

	localparam logic [COL_W-1:0]  LAST_COL  = COL_W'(COLUMNS - 1);
	localparam logic [ROW_W-1:0]  LAST_ROW  = ROW_W'(ROWS - 1);
	localparam logic [ADDR_W-1:0] LAST_CELL = ADDR_W'(CELLS - 1);
	localparam logic [ADDR_W-1:0] COPY_END  = ADDR_W'(CELLS - COLUMNS);
	localparam logic [ADDR_W-1:0] ROW_STEP  = ADDR_W'(COLUMNS);

	logic [1:0]        state_q;
	logic [ADDR_W-1:0] cnt_q;
	logic [COL_W-1:0]  col_q;
	logic [ROW_W-1:0]  row_q;
	logic [ADDR_W-1:0] offset_q;
	logic              done_q;
	logic              cell_vld_q;
	logic [7:0]        fill_attr_q;
	logic [7:0]        scroll_fill_q;

	// Write stage of the scroll sweep: the cell read in the previous cycle lands here.
	logic              wr_vld_s1;
	logic [ADDR_W-1:0] wr_addr_s1;
	logic              wr_fill_s1;

	logic              accept;
	logic [COL_W-1:0]  nxt_col;
	logic [ROW_W-1:0]  nxt_row;
	logic              do_write;
	logic              do_read;
	logic              go_scroll;
	logic              go_clear;
	logic [ADDR_W-1:0] cur_addr;
	logic [ADDR_W-1:0] pos_addr;
	logic [ADDR_W-1:0] item_addr;
	logic              in_range;

	fb_wr_t            wr;
	fb_rd_t            rd;
	logic [CELL_W-1:0] rdata;

	function automatic logic [ADDR_W-1:0] lin_addr(logic [COL_W-1:0] c, logic [ROW_W-1:0] r);
		return ADDR_W'(c) + ADDR_W'(r) * ROW_STEP;
	endfunction

	// A command is never taken while a sweep runs or its last write is pending.
	assign busy      = (state_q != ST_RUN) || wr_vld_s1;
	assign accept    = start && !busy;
	assign cfg_ready = 1'b1;

	assign in_range = (pos_x < COL_W'(COLUMNS)) && (pos_y < ROW_W'(ROWS));
	assign cur_addr = lin_addr(col_q, row_q);
	assign pos_addr = lin_addr(pos_x, pos_y);

	// Cursor update and memory intent of the command on the ports.
	always_comb begin
		nxt_col   = col_q;
		nxt_row   = row_q;
		do_write  = 1'b0;
		do_read   = 1'b0;
		go_scroll = 1'b0;
		go_clear  = 1'b0;
		item_addr = pos_addr;
		unique case (func)
			FN_PUT_CUR: begin
				item_addr = cur_addr;
				priority if (char_code == BS_CODE) begin
					// Backspace wraps to the end of the row above and stops at the top.
					if (col_q != '0) begin
						nxt_col = col_q - 1'b1;
					end else begin
						nxt_col = LAST_COL;
						if (row_q != '0) begin
							nxt_row = row_q - 1'b1;
						end
					end
				end else if (char_code == NL_CODE) begin
					nxt_col = '0;
					if (row_q == LAST_ROW) begin
						go_scroll = 1'b1;
					end else begin
						nxt_row = row_q + 1'b1;
					end
				end else begin
					do_write = 1'b1;
					if (col_q == LAST_COL) begin
						nxt_col = '0;
						if (row_q == LAST_ROW) begin
							go_scroll = 1'b1;
						end else begin
							nxt_row = row_q + 1'b1;
						end
					end else begin
						nxt_col = col_q + 1'b1;
					end
				end
			end
			FN_PUT_POS: begin
				do_write = in_range;
			end
			FN_SET_CUR: begin
				nxt_col = (pos_x < COL_W'(COLUMNS)) ? pos_x : LAST_COL;
				nxt_row = (pos_y < ROW_W'(ROWS)) ? pos_y : LAST_ROW;
			end
			FN_CLEAR: begin
				nxt_col  = '0;
				nxt_row  = '0;
				go_clear = 1'b1;
			end
			FN_READ: begin
				do_read = in_range;
			end
			default: begin
			end
		endcase
	end

	// Memory port selection. The sweep write stage and a command never meet,
	// since busy holds commands off while either sweep is active.
	always_comb begin
		wr = '0;
		rd = '0;
		if (wr_vld_s1) begin
			wr.en   = 1'b1;
			wr.addr = wr_addr_s1;
			wr.data = wr_fill_s1 ? {scroll_fill_q, 8'h00} : rdata;
		end else if (state_q == ST_CLEAR) begin
			wr.en   = 1'b1;
			wr.addr = cnt_q;
		end else if (accept && do_write) begin
			wr.en   = 1'b1;
			wr.addr = item_addr;
			wr.data = {attribute, char_code};
		end
		if (state_q == ST_SCROLL) begin
			// Row r+1 is read in the cycle before it is written into row r.
			rd.en   = cnt_q < COPY_END;
			rd.addr = cnt_q + ROW_STEP;
		end else if (accept && do_read) begin
			rd.en   = 1'b1;
			rd.addr = pos_addr;
		end
	end

	tmcw_fbuf u_fbuf (
		.clk   (clk),
		.wr    (wr),
		.rd    (rd),
		.rdata (rdata)
	);

	// Sweep sequencer; reset starts with a clearing pass over the whole buffer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			cnt_q     <= '0;
			wr_vld_s1 <= 1'b0;
		end else begin
			wr_vld_s1 <= (state_q == ST_SCROLL);
			unique case (state_q)
				ST_RUN: begin
					cnt_q <= '0;
					if (accept && go_scroll) begin
						state_q <= ST_SCROLL;
					end else if (accept && go_clear) begin
						state_q <= ST_CLEAR;
					end
				end
				ST_CLEAR, ST_SCROLL: begin
					if (cnt_q == LAST_CELL) begin
						state_q <= ST_RUN;
						cnt_q   <= '0;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				default: begin
					state_q <= ST_RUN;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		wr_addr_s1 <= cnt_q;
		wr_fill_s1 <= cnt_q >= COPY_END;
		if (accept && go_scroll) begin
			scroll_fill_q <= fill_attr_q;
		end
	end

	// Cursor, result strobe and configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q       <= '0;
			row_q       <= '0;
			offset_q    <= '0;
			done_q      <= 1'b0;
			cell_vld_q  <= 1'b0;
			fill_attr_q <= 8'd7;
		end else begin
			done_q <= accept;
			if (accept) begin
				col_q      <= nxt_col;
				row_q      <= nxt_row;
				offset_q   <= lin_addr(nxt_col, nxt_row);
				cell_vld_q <= do_read;
			end
			if (cfg_valid && cfg_ready) begin
				fill_attr_q <= cfg_data;
			end
		end
	end

	assign done          = done_q;
	assign cursor_col    = col_q;
	assign cursor_row    = row_q;
	assign cursor_offset = offset_q;
	assign cell_value    = cell_vld_q ? rdata : '0;

	// The cursor never leaves the screen.
	a_cursor_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		(col_q < COL_W'(COLUMNS)) && (row_q < ROW_W'(ROWS)))
		else $error("cursor outside the screen");

	// The reported offset always matches the reported column and row.
	a_offset: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (cursor_offset == lin_addr(cursor_col, cursor_row)))
		else $error("cursor offset does not match column and row");

	// A sweep write is only pending in the cycle after a scroll step.
	a_sweep_stage: assert property (@(posedge clk) disable iff (!arst_n)
		wr_vld_s1 |-> $past(state_q == ST_SCROLL))
		else $error("scroll write stage valid outside a scroll");

	// A scroll or clear command raises busy in the following cycle.
	a_sweep_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (go_scroll || go_clear)) |=> busy)
		else $error("sweep started without busy");

endmodule

// ===== sim/text_mode_console_writer_tb.sv =====
// Self-checking testbench for the text-mode console writer.
// It drives command beats, predicts every cursor and cell result and compares them on done.
// Depends on tmcw_pkg and the text_mode_console_writer RTL only.
`timescale 1ns / 1ps

module text_mode_console_writer_tb;
	import tmcw_pkg::*;

	// Function codes 5 to 7 are unused by the block; these two bound that range.
	localparam logic [2:0] FN_SPARE_LO = 3'd5;
	localparam logic [2:0] FN_SPARE_HI = 3'd7;

	// A scroll or clear keeps busy high for a whole sweep of the buffer, so the cycle limit
	// assumes every beat could cost a full sweep on top of the longest sender gaps.
	localparam int CYCLE_LIMIT  = 20_000_000;
	localparam int PHASE_ITEMS  = 160;
	localparam int QUIET_CYCLES = 3;

	typedef struct {
		logic [2:0] func;
		logic [6:0] pos_x;
		logic [4:0] pos_y;
		logic [7:0] char_code;
		logic [7:0] attribute;
		bit         hold;	// wait for every outstanding result before issuing
	} console_cmd_t;

	typedef struct {
		logic [6:0]  cursor_col;
		logic [4:0]  cursor_row;
		logic [10:0] cursor_offset;
		logic [15:0] cell_value;
	} cursor_report_t;

	// Clock, reset and every input of the block start at a known value.
	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        start     = 1'b0;
	logic [2:0]  func      = '0;
	logic [6:0]  pos_x     = '0;
	logic [4:0]  pos_y     = '0;
	logic [7:0]  char_code = '0;
	logic [7:0]  attribute = '0;
	logic        cfg_valid = 1'b0;
	logic [7:0]  cfg_data  = '0;

	logic        busy;
	logic        done;
	logic [6:0]  cursor_col;
	logic [4:0]  cursor_row;
	logic [10:0] cursor_offset;
	logic [15:0] cell_value;
	logic        cfg_ready;

	// Commands waiting to be sent, and cursor reports owed by the block in issue order.
	console_cmd_t   cmd_backlog [$];
	cursor_report_t owed_reports [$];

	// The testbench's own copy of the console state.
	logic [15:0] screen_model [CELLS];
	int          cur_col;
	int          cur_row;
	logic [7:0]  fill_attr_m = 8'd7;

	console_cmd_t   issued_cmd;
	cursor_report_t predicted;
	cursor_report_t seen;

	// Beat counters are updated with nonblocking assignments so that every process
	// reads the value from before the current edge.
	int n_sent    = 0;
	int n_back    = 0;
	int idle_pct  = 0;
	int n_err     = 0;
	int n_scrolls = 0;
	int n_clears  = 0;
	int n_fills   = 0;
	int n_queued  = 0;
	int cycles    = 0;

	text_mode_console_writer i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.func         (func),
		.pos_x        (pos_x),
		.pos_y        (pos_y),
		.char_code    (char_code),
		.attribute    (attribute),
		.done         (done),
		.cursor_col   (cursor_col),
		.cursor_row   (cursor_row),
		.cursor_offset(cursor_offset),
		.cell_value   (cell_value),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data)
	);

	always #2 clk = ~clk;

	// Moving down from the bottom row shifts the whole screen up one row and fills the
	// freed row with the fill attribute and character zero; the cursor stays on it.
	task automatic advance_row();
		if (cur_row + 1 >= ROWS) begin
			for (int i = 0; i + COLUMNS < CELLS; i++)
				screen_model[i] = screen_model[i + COLUMNS];
			for (int i = CELLS - COLUMNS; i < CELLS; i++)
				screen_model[i] = {fill_attr_m, 8'h00};
			cur_row = ROWS - 1;
			n_scrolls++;
		end else begin
			cur_row++;
		end
	endtask

	// Applies one accepted command to the model and gives the report the block must return.
	task automatic console_apply(input console_cmd_t c, output cursor_report_t r);
		logic [15:0] cell_word;
		bit          in_range;
		int          offset;
		cell_word = '0;
		in_range = (c.pos_x < COLUMNS) && (c.pos_y < ROWS);
		case (c.func)
			FN_PUT_CUR: begin
				if (c.char_code == BS_CODE) begin
					// Backspace erases nothing; from column zero it goes to the end of
					// the row above, but never above the top row.
					if (cur_col > 0) begin
						cur_col--;
					end else begin
						cur_col = COLUMNS - 1;
						if (cur_row > 0)
							cur_row--;
					end
				end else if (c.char_code == NL_CODE) begin
					cur_col = 0;
					advance_row();
				end else begin
					screen_model[cur_col + cur_row * COLUMNS] = {c.attribute, c.char_code};
					cur_col++;
					if (cur_col >= COLUMNS) begin
						cur_col = 0;
						advance_row();
					end
				end
			end
			FN_PUT_POS: begin
				if (in_range)
					screen_model[c.pos_x + c.pos_y * COLUMNS] = {c.attribute, c.char_code};
			end
			FN_SET_CUR: begin
				// Out-of-range coordinates saturate to the last column and row.
				cur_col = (c.pos_x < COLUMNS) ? int'(c.pos_x) : COLUMNS - 1;
				cur_row = (c.pos_y < ROWS) ? int'(c.pos_y) : ROWS - 1;
			end
			FN_CLEAR: begin
				foreach (screen_model[i])
					screen_model[i] = '0;
				cur_col = 0;
				cur_row = 0;
				n_clears++;
			end
			FN_READ: begin
				if (in_range)
					cell_word = screen_model[c.pos_x + c.pos_y * COLUMNS];
			end
			default: begin
			end
		endcase
		offset = cur_col + cur_row * COLUMNS;
		r.cursor_col    = cur_col[6:0];
		r.cursor_row    = cur_row[4:0];
		r.cursor_offset = offset[10:0];
		r.cell_value    = cell_word;
	endtask

	// Driver. A beat is taken at an edge with start high and busy low; the beat is
	// predicted right there, and the next command (or an idle cycle) is chosen. A held
	// command waits until every report already owed has come back.
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy) begin
				console_apply(issued_cmd, predicted);
				owed_reports.push_back(predicted);
				n_sent <= n_sent + 1;
			end
			if (!start || !busy) begin
				if (cmd_backlog.size() != 0 && $urandom_range(0, 99) >= idle_pct &&
				    !(cmd_backlog[0].hold && (start || n_sent != n_back))) begin
					issued_cmd = cmd_backlog.pop_front();
					start     <= 1'b1;
					func      <= issued_cmd.func;
					pos_x     <= issued_cmd.pos_x;
					pos_y     <= issued_cmd.pos_y;
					char_code <= issued_cmd.char_code;
					attribute <= issued_cmd.attribute;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// Monitor. done marks one result beat, taken at the edge that ends its cycle.
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (owed_reports.size() == 0) begin
				$error("result beat with nothing outstanding: col %0d row %0d",
				       cursor_col, cursor_row);
				n_err++;
			end else begin
				seen = owed_reports.pop_front();
				if (cursor_col !== seen.cursor_col) begin
					$error("cursor_col: expected %0d, got %0d", seen.cursor_col, cursor_col);
					n_err++;
				end
				if (cursor_row !== seen.cursor_row) begin
					$error("cursor_row: expected %0d, got %0d", seen.cursor_row, cursor_row);
					n_err++;
				end
				if (cursor_offset !== seen.cursor_offset) begin
					$error("cursor_offset: expected %0d, got %0d",
					       seen.cursor_offset, cursor_offset);
					n_err++;
				end
				if (cell_value !== seen.cell_value) begin
					$error("cell_value: expected 0x%04h, got 0x%04h", seen.cell_value, cell_value);
					n_err++;
				end
			end
			n_back <= n_back + 1;
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("text_mode_console_writer: mismatch");
			$finish;
		end
	end

	task automatic queue_cmd(input logic [2:0] f, input int x, input int y,
	                         input int ch, input int at);
		console_cmd_t c;
		c.func      = f;
		c.pos_x     = x[6:0];
		c.pos_y     = y[4:0];
		c.char_code = ch[7:0];
		c.attribute = at[7:0];
		c.hold      = ($urandom_range(0, 49) == 0);
		cmd_backlog.push_back(c);
		n_queued++;
	endtask

	// Coordinates lean toward the edges of the screen, just past them and the largest field value.
	function automatic int pick_col();
		int edges [5] = '{0, COLUMNS - 2, COLUMNS - 1, COLUMNS, 127};
		if ($urandom_range(0, 3) == 0)
			return edges[$urandom_range(0, 4)];
		return $urandom_range(0, COLUMNS - 1);
	endfunction

	function automatic int pick_row();
		int edges [5] = '{0, ROWS - 2, ROWS - 1, ROWS, 31};
		if ($urandom_range(0, 3) == 0)
			return edges[$urandom_range(0, 4)];
		return $urandom_range(0, ROWS - 1);
	endfunction

	function automatic int pick_char();
		case ($urandom_range(0, 7))
			0:       return int'(BS_CODE);
			1:       return int'(NL_CODE);
			default: return $urandom_range(0, 255);
		endcase
	endfunction

	// Random phase: mostly short meaningful sequences (text runs after a cursor move,
	// write then read back, a forced scroll then reads of the bottom rows), with some
	// clears, plain reads and fully random noise mixed in.
	task automatic queue_random(input int n);
		int kind;
		int k;
		int x;
		int y;
		int f;
		int got;
		got = 0;
		while (got < n) begin
			kind = $urandom_range(0, 99);
			if (kind < 40) begin
				queue_cmd(FN_SET_CUR, pick_col(), pick_row(), $urandom_range(0, 255),
				          $urandom_range(0, 255));
				k = $urandom_range(1, 8);
				repeat (k)
					queue_cmd(FN_PUT_CUR, $urandom_range(0, 127), $urandom_range(0, 31),
					          pick_char(), $urandom_range(0, 255));
				got += k + 1;
			end else if (kind < 60) begin
				x = pick_col();
				y = pick_row();
				queue_cmd(FN_PUT_POS, x, y, $urandom_range(0, 255), $urandom_range(0, 255));
				if ($urandom_range(0, 1))
					queue_cmd(FN_PUT_CUR, x, y, pick_char(), $urandom_range(0, 255));
				queue_cmd(FN_READ, x, y, $urandom_range(0, 255), $urandom_range(0, 255));
				got += 3;
			end else if (kind < 70) begin
				if ($urandom_range(0, 1)) begin
					queue_cmd(FN_SET_CUR, $urandom_range(0, COLUMNS - 1),
					          $urandom_range(0, 1) ? ROWS - 1 : 31, 0, 0);
					queue_cmd(FN_PUT_CUR, 0, 0, NL_CODE, $urandom_range(0, 255));
				end else begin
					queue_cmd(FN_SET_CUR, COLUMNS - 1, ROWS - 1, 0, 0);
					queue_cmd(FN_PUT_CUR, 0, 0, $urandom_range(0, 255), $urandom_range(0, 255));
				end
				queue_cmd(FN_READ, $urandom_range(0, COLUMNS - 1), ROWS - 1, 0, 0);
				queue_cmd(FN_READ, $urandom_range(0, COLUMNS - 1), ROWS - 2, 0, 0);
				got += 4;
			end else if (kind < 72) begin
				queue_cmd(FN_CLEAR, $urandom_range(0, 127), $urandom_range(0, 31),
				          $urandom_range(0, 255), $urandom_range(0, 255));
				queue_cmd(FN_READ, pick_col(), pick_row(), 0, 0);
				got += 2;
			end else if (kind < 85) begin
				queue_cmd(FN_READ, pick_col(), pick_row(), $urandom_range(0, 255),
				          $urandom_range(0, 255));
				got++;
			end else begin
				f = $urandom_range(0, 7);
				queue_cmd(3'(f), $urandom_range(0, 127), $urandom_range(0, 31),
				          $urandom_range(0, 255), $urandom_range(0, 255));
				if (f <= FN_READ)
					got++;
			end
		end
	endtask

	// Returns at a rising edge once nothing is queued or owed and busy has been low for a
	// few edges in a row, so a scroll or clear that follows its report has also finished.
	task automatic wait_quiet();
		int calm;
		calm = 0;
		while (calm < QUIET_CYCLES) begin
			@(posedge clk);
			if (cmd_backlog.size() == 0 && !start && n_sent == n_back && !busy)
				calm++;
			else
				calm = 0;
		end
	endtask

	// Writes the fill attribute; called right after a rising edge while the block is idle.
	task automatic write_fill(input logic [7:0] v);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		fill_attr_m = v;
		n_fills++;
	endtask

	initial begin
		logic [7:0] fill_plan [5];
		int         idle_plan [5];
		int         n_directed;
		fill_plan = '{8'h00, 8'hFF, 8'h00, 8'h80, 8'h07};
		fill_plan[2] = 8'($urandom_range(1, 254));
		idle_plan = '{0, 53, 0, 31, 53};
		foreach (screen_model[i])
			screen_model[i] = '0;
		cur_col = 0;
		cur_row = 0;

		repeat (3)
			@(posedge clk);
		arst_n <= 1'b1;

		// Directed commands, run with the reset fill attribute. The block first runs its
		// clearing pass; the driver simply waits for busy to drop.
		@(negedge clk);
		queue_cmd(FN_READ, 0, 0, 0, 0);
		queue_cmd(FN_PUT_CUR, 0, 0, 8'h41, 8'h1F);
		queue_cmd(FN_PUT_CUR, 0, 0, BS_CODE, 8'h00);
		// Backspace at the home position wraps to the last column of the top row.
		queue_cmd(FN_PUT_CUR, 0, 0, BS_CODE, 8'hFF);
		queue_cmd(FN_PUT_CUR, 0, 0, NL_CODE, 8'h00);
		queue_cmd(FN_PUT_CUR, 127, 31, 8'h00, 8'hFF);
		queue_cmd(FN_PUT_POS, COLUMNS - 1, ROWS - 1, 8'hFF, 8'hFF);
		queue_cmd(FN_READ, COLUMNS - 1, ROWS - 1, 8'hFF, 8'hFF);
		// Positions off the screen write nothing and read back as zero.
		queue_cmd(FN_PUT_POS, COLUMNS, 0, 8'h55, 8'hAA);
		queue_cmd(FN_PUT_POS, 127, 31, 8'hFF, 8'hFF);
		queue_cmd(FN_READ, COLUMNS, 0, 0, 0);
		queue_cmd(FN_READ, 0, ROWS, 0, 0);
		// Saturating cursor move to the bottom right corner, then a character there,
		// which wraps and scrolls.
		queue_cmd(FN_SET_CUR, 127, 31, 0, 0);
		queue_cmd(FN_PUT_CUR, 0, 0, 8'h5A, 8'h1E);
		queue_cmd(FN_READ, COLUMNS - 1, ROWS - 2, 0, 0);
		cmd_backlog[cmd_backlog.size() - 1].hold = 1'b1;
		queue_cmd(FN_READ, 0, ROWS - 1, 0, 0);
		// Newline on the bottom row scrolls again.
		queue_cmd(FN_PUT_CUR, 0, 0, NL_CODE, 8'h00);
		queue_cmd(FN_READ, COLUMNS - 1, ROWS - 3, 0, 0);
		// Wrap at the end of a row that is not the last one.
		queue_cmd(FN_SET_CUR, COLUMNS - 1, 0, 0, 0);
		queue_cmd(FN_PUT_CUR, 0, 0, 8'h71, 8'h00);
		// Backspace from column zero goes to the end of the row above.
		queue_cmd(FN_SET_CUR, 0, 5, 0, 0);
		queue_cmd(FN_PUT_CUR, 0, 0, BS_CODE, 8'h00);
		queue_cmd(FN_SPARE_LO, 127, 31, 8'hFF, 8'hFF);
		queue_cmd(FN_SPARE_HI, 127, 31, 8'hFF, 8'hFF);
		queue_cmd(FN_CLEAR, 0, 0, 0, 0);
		queue_cmd(FN_READ, COLUMNS - 1, ROWS - 3, 0, 0);
		n_directed = n_queued;

		// Random phases, each after a fill attribute write and with a sender idling level from idle_plan.
		foreach (fill_plan[p]) begin
			wait_quiet();
			write_fill(fill_plan[p]);
			idle_pct <= idle_plan[p];
			@(negedge clk);
			queue_random(PHASE_ITEMS);
		end

		wait_quiet();
		repeat (4)
			@(posedge clk);
		if (owed_reports.size() != 0) begin
			$error("%0d cursor reports never arrived", owed_reports.size());
			n_err++;
		end

		$display("Sent %0d commands (%0d directed) under %0d fill attribute settings.",
		         n_queued, n_directed, n_fills);
		$display("Model saw %0d scrolls and %0d clears; %0d field errors.",
		         n_scrolls, n_clears, n_err);
		if (n_err == 0) begin
			$display("text_mode_console_writer: match");
		end else begin
			$display("text_mode_console_writer: mismatch");
		end
		$finish;
	end

endmodule
